>>> rtl/core/assert_macros.svh
// Assertion macros for the RTL of the vector target region classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge and switched off while in reset.
`define VTRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication in the same cycle.
`define VTRC_ASSERT_IMP(lbl, ante, cons, msg) \
  `VTRC_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

>>> rtl/core/vtrc_pkg.sv
// Shared types and constants of the vector target region classifier.
package vtrc_pkg;

  localparam int unsigned RegionSlotsDef = 16;
  localparam int unsigned AddrW          = 32;
  localparam int unsigned CountW         = 5;
  localparam int unsigned SlotW          = 4;
  localparam int unsigned ScoreW         = 6;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_ANALYZE = 1'b1;

  localparam logic [2:0] OWNER_UNKNOWN  = 3'd0;
  localparam logic [2:0] OWNER_ROM      = 3'd1;
  localparam logic [2:0] OWNER_LIBRARY  = 3'd2;
  localparam logic [2:0] OWNER_DEVICE   = 3'd3;
  localparam logic [2:0] OWNER_RESIDENT = 3'd4;

  localparam logic [1:0] REG_LIVE_SLOTS = 2'd0;

  localparam logic [ScoreW-1:0] SCORE_BASE     = 6'd15;
  localparam logic [ScoreW-1:0] WEIGHT_UNKNOWN = 6'd30;
  localparam logic [ScoreW-1:0] WEIGHT_PATCH   = 6'd10;  // subtracted
  localparam logic [ScoreW-1:0] WEIGHT_NONEXEC = 6'd25;
  localparam logic [ScoreW-1:0] WEIGHT_MODULE  = 6'd5;
  localparam logic [ScoreW-1:0] WEIGHT_RAM     = 6'd20;

  typedef enum logic [2:0] {
    FIND_EXPECTED      = 3'd0,
    FIND_UNKNOWN       = 3'd1,
    FIND_ALLOWED_PATCH = 3'd2,
    FIND_NONEXEC       = 3'd3,
    FIND_ROM           = 3'd4,
    FIND_KNOWN_MODULE  = 3'd5,
    FIND_EXEC_RAM      = 3'd6
  } finding_e;

  typedef struct packed {
    logic       exec;
    logic       patch;
    logic [2:0] owner;
  } region_attr_t;

  typedef struct packed {
    logic [AddrW-1:0] lo;
    logic [AddrW-1:0] hi;
    region_attr_t     attr;
  } region_entry_t;

  typedef struct packed {
    logic             en;
    logic [SlotW-1:0] slot;
    region_entry_t    entry;
  } table_wr_t;

endpackage

>>> rtl/core/vtrc_region_match.sv
// Region table with one comparator lane per entry and the expected-range check.
module vtrc_region_match import vtrc_pkg::*; #(
  parameter int unsigned RegionSlots = RegionSlotsDef
) (
  input  logic                    clk_i,
  input  table_wr_t               wr_i,
  input  logic [CountW-1:0]       count_i,
  input  logic [AddrW-1:0]        target_i,
  input  logic [AddrW-1:0]        exp_lo_i,
  input  logic [AddrW-1:0]        exp_hi_i,
  output logic                    exp_hit_o,
  output logic [RegionSlots-1:0]  hit_o,
  output region_attr_t            attr_o [RegionSlots]
);

  localparam int unsigned IdxW  = (RegionSlots > 1) ? $clog2(RegionSlots) : 1;
  localparam int unsigned SlotCmpW = ((IdxW > SlotW) ? IdxW : SlotW) + 1;
  localparam int unsigned LaneW = ((IdxW + 1) > CountW) ? (IdxW + 1) : CountW;

  region_entry_t entries_q [RegionSlots];
  logic          slot_ok;

  // Loads to a slot beyond the table are dropped.
  assign slot_ok = SlotCmpW'(wr_i.slot) < SlotCmpW'(RegionSlots);

  always_ff @(posedge clk_i) begin
    if (wr_i.en && slot_ok) begin
      entries_q[IdxW'(wr_i.slot)] <= wr_i.entry;
    end
  end

  assign exp_hit_o = (exp_lo_i <= exp_hi_i) && (target_i >= exp_lo_i) &&
                     (target_i <= exp_hi_i);

  for (genvar i = 0; i < RegionSlots; i++) begin : g_lane
    logic active;
    assign active = LaneW'(i) < LaneW'(count_i);
    assign hit_o[i] = active &&
                      (entries_q[i].lo <= entries_q[i].hi) &&
                      (target_i >= entries_q[i].lo) &&
                      (target_i <= entries_q[i].hi);
    assign attr_o[i] = entries_q[i].attr;
  end

endmodule

>>> rtl/core/vector_target_region_classifier.sv
// Top level of the vector target region classifier: stream ports, APB register and pipeline.
//
// The classifier keeps a table of address regions and sorts the target of a jump vector
// against it. A load item (tuser 0) writes one table slot; slots at or above RegionSlots
// are ignored and the item still returns an all-zero result. An analyze item (tuser 1)
// scores 0 when the target lies in its expected range; otherwise the lowest active slot
// (below the live slot count, which is clamped to RegionSlots) that contains the target is
// chosen and the result carries its flags, owner, index, a finding and a score of 15 plus
// the finding weight, which is subtracted for an allowed patch. Every item returns exactly
// one result, in order. The pipeline takes one item per cycle unless the output stalls, and
// has four register stages: input register, parallel lane compare, priority pick, scoring
// into the output register. Every stage moves whenever the one after it is empty or
// moving, so bubbles close up under back-pressure. Table writes happen as a load leaves
// the input register, so an analyze item sees every load accepted before it; the lane
// stage captures the flags of each slot so that later loads cannot change an item already
// past the compare. Slots that were never loaded hold unknown contents, and the live slot
// count must not cover them when analyzing. The single register, the live slot count, lies
// at byte address 0 and is to be written only while the block is idle; the user must keep
// to this, since the block itself does not enforce it.
`include "assert_macros.svh"

module vector_target_region_classifier import vtrc_pkg::*; #(
  parameter int unsigned RegionSlots = RegionSlotsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // s_axis_tdata_i: region_index[3:0], region_start[35:4], region_end[67:36],
  // region_executable[68], region_allow_patch[69], region_owner[72:70],
  // target_address[104:73], expected_low[136:105], expected_high[168:137], zeros above.
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [175:0] s_axis_tdata_i,
  // s_axis_tuser_i: mode[0].
  input  logic         s_axis_tuser_i,
  // m_axis_tdata_o: in_expected_range[0], in_known_region[1], target_executable[2],
  // target_patchable[3], owner[6:4], matched_region[10:7], final_finding[13:11],
  // findings[15:14], score[21:16], zeros above.
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [23:0]  m_axis_tdata_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned IdxW = (RegionSlots > 1) ? $clog2(RegionSlots) : 1;

  typedef struct packed {
    logic             in_exp;
    logic             known;
    logic             exec;
    logic             patch;
    logic [2:0]       owner;
    logic [SlotW-1:0] matched;
    finding_e         finding;
    logic [1:0]       count;
    logic [ScoreW-1:0] score;
  } result_t;

  // Configuration register.
  logic [CountW-1:0] live_slots_q;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_LIVE_SLOTS) ? {{(32 - CountW){1'b0}}, live_slots_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_slots_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr == REG_LIVE_SLOTS)) begin
      live_slots_q <= pwdata[CountW-1:0];
    end
  end

  // Stage enables: a stage loads when it is empty or its content moves on.
  logic v0_q, v1_q, v2_q, v3_q;
  logic en0, en1, en2, en3;

  assign en3 = !v3_q || m_axis_tready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;
  assign s_axis_tready_o = en0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en0) v0_q <= s_axis_tvalid_i;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Stage 0: input register.
  logic          mode0_q;
  logic [SlotW-1:0] slot0_q;
  region_entry_t entry0_q;
  logic [AddrW-1:0] target0_q, exp_lo0_q, exp_hi0_q;

  always_ff @(posedge clk_i) begin
    if (en0 && s_axis_tvalid_i) begin
      mode0_q         <= s_axis_tuser_i;
      slot0_q         <= s_axis_tdata_i[3:0];
      entry0_q.lo     <= s_axis_tdata_i[35:4];
      entry0_q.hi     <= s_axis_tdata_i[67:36];
      entry0_q.attr.exec  <= s_axis_tdata_i[68];
      entry0_q.attr.patch <= s_axis_tdata_i[69];
      entry0_q.attr.owner <= s_axis_tdata_i[72:70];
      target0_q       <= s_axis_tdata_i[104:73];
      exp_lo0_q       <= s_axis_tdata_i[136:105];
      exp_hi0_q       <= s_axis_tdata_i[168:137];
    end
  end

  // Lane compare against the table; a load writes as it leaves stage 0.
  table_wr_t            tbl_wr;
  logic                 exp_hit;
  logic [RegionSlots-1:0] hit;
  region_attr_t         lane_attr [RegionSlots];

  assign tbl_wr.en    = v0_q && en1 && (mode0_q == MODE_LOAD);
  assign tbl_wr.slot  = slot0_q;
  assign tbl_wr.entry = entry0_q;

  vtrc_region_match #(
    .RegionSlots (RegionSlots)
  ) u_match (
    .clk_i     (clk_i),
    .wr_i      (tbl_wr),
    .count_i   (live_slots_q),
    .target_i  (target0_q),
    .exp_lo_i  (exp_lo0_q),
    .exp_hi_i  (exp_hi0_q),
    .exp_hit_o (exp_hit),
    .hit_o     (hit),
    .attr_o    (lane_attr)
  );

  // Stage 1: hit vector and a snapshot of every lane's flags.
  logic                   mode1_q, exp1_q;
  logic [RegionSlots-1:0] hit1_q;
  region_attr_t           attr1_q [RegionSlots];

  always_ff @(posedge clk_i) begin
    if (en1 && v0_q) begin
      mode1_q <= mode0_q;
      exp1_q  <= exp_hit;
      hit1_q  <= hit;
      attr1_q <= lane_attr;
    end
  end

  // Stage 2: priority pick of the lowest hitting slot.
  logic [RegionSlots-1:0] first_hit;
  logic [IdxW-1:0]        pick_idx;
  region_attr_t           pick_attr;

  assign first_hit = hit1_q & (~hit1_q + RegionSlots'(1));

  always_comb begin
    pick_idx  = '0;
    pick_attr = '0;
    for (int i = 0; i < RegionSlots; i++) begin
      if (first_hit[i]) begin
        pick_idx  = pick_idx | IdxW'(i);
        pick_attr = pick_attr | attr1_q[i];
      end
    end
  end

  logic             mode2_q, exp2_q, known2_q;
  logic [IdxW-1:0]  idx2_q;
  region_attr_t     attr2_q;

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      mode2_q  <= mode1_q;
      exp2_q   <= exp1_q;
      known2_q <= |hit1_q;
      idx2_q   <= pick_idx;
      attr2_q  <= pick_attr;
    end
  end

  // Stage 3: finding and score into the output register.
  result_t res_d, res_q;

  always_comb begin
    res_d = '0;
    if (mode2_q == MODE_ANALYZE) begin
      if (exp2_q) begin
        res_d.in_exp  = 1'b1;
        res_d.finding = FIND_EXPECTED;
        res_d.count   = 2'd1;
      end else begin
        res_d.count = 2'd2;
        if (!known2_q) begin
          res_d.finding = FIND_UNKNOWN;
          res_d.score   = SCORE_BASE + WEIGHT_UNKNOWN;
        end else begin
          res_d.known   = 1'b1;
          res_d.exec    = attr2_q.exec;
          res_d.patch   = attr2_q.patch;
          res_d.owner   = attr2_q.owner;
          res_d.matched = SlotW'(idx2_q);
          if (attr2_q.patch) begin
            res_d.finding = FIND_ALLOWED_PATCH;
            res_d.score   = SCORE_BASE - WEIGHT_PATCH;
          end else if (!attr2_q.exec) begin
            res_d.finding = FIND_NONEXEC;
            res_d.score   = SCORE_BASE + WEIGHT_NONEXEC;
          end else begin
            case (attr2_q.owner) inside
              OWNER_ROM: begin
                res_d.finding = FIND_ROM;
                res_d.score   = SCORE_BASE;
              end
              OWNER_LIBRARY, OWNER_DEVICE, OWNER_RESIDENT: begin
                res_d.finding = FIND_KNOWN_MODULE;
                res_d.score   = SCORE_BASE + WEIGHT_MODULE;
              end
              default: begin
                res_d.finding = FIND_EXEC_RAM;
                res_d.score   = SCORE_BASE + WEIGHT_RAM;
              end
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = v3_q;
  assign m_axis_tdata_o  = {2'b00, res_q.score, res_q.count, res_q.finding, res_q.matched,
                            res_q.owner, res_q.patch, res_q.exec, res_q.known, res_q.in_exp};

  // An expected hit always scores zero and is the only single-finding result.
  `VTRC_ASSERT_IMP(a_expected_scores_zero, v3_q && (res_q.count == 2'd1),
                   res_q.in_exp && (res_q.score == '0), "expected hit with nonzero score")
  // An unknown target carries the full penalty and no region fields.
  `VTRC_ASSERT_IMP(a_unknown_full_score, v3_q && (res_q.count == 2'd2) && !res_q.known,
                   (res_q.score == SCORE_BASE + WEIGHT_UNKNOWN) && (res_q.matched == '0) &&
                   (res_q.owner == OWNER_UNKNOWN), "unknown target result malformed")
  // The input side is held off only while every pipeline stage is occupied.
  `VTRC_ASSERT_IMP(a_ready_only_when_full, !s_axis_tready_o, v0_q && v1_q && v2_q && v3_q,
                   "input stalled with an empty stage in the pipeline")

endmodule

>>> tb/sv/tb_top.sv
// Self-checking stream testbench for the vector target region classifier.
`timescale 1ns / 100ps

module tb_top import vtrc_pkg::*; ();

  localparam int unsigned ClkPeriod  = 8;
  localparam int unsigned ResetCycles = 10;
  localparam int unsigned TableDepth = RegionSlotsDef;
  localparam int unsigned LongHold   = 48;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainWait  = 20;
  localparam int unsigned PhaseItems = 240;
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned ReportMax  = 10;

  // Byte address of the live slot count register on the APB port.
  localparam logic [1:0] LiveSlotsAddr = 2'(REG_LIVE_SLOTS * 4);

  // Owner kinds that the package leaves unnamed all count as plain RAM.
  localparam logic [2:0] OwnerOtherLo = 3'd5;
  localparam logic [2:0] OwnerOtherHi = 3'd7;

  // Input item as it travels on tdata, highest field first.
  typedef struct packed {
    logic [6:0]  spare;
    logic [31:0] exp_hi;
    logic [31:0] exp_lo;
    logic [31:0] target;
    logic [2:0]  owner;
    logic        patch;
    logic        exec;
    logic [31:0] hi;
    logic [31:0] lo;
    logic [3:0]  slot;
  } vector_fields_t;

  typedef struct packed {
    logic           mode;
    vector_fields_t f;
  } vector_item_t;

  // Classification result as it travels on tdata, highest field first.
  typedef struct packed {
    logic [1:0] spare;
    logic [5:0] score;
    logic [1:0] finding_cnt;
    finding_e   finding;
    logic [3:0] region_idx;
    logic [2:0] owner;
    logic       patchable;
    logic       executable;
    logic       in_known;
    logic       in_expected;
  } verdict_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [175:0] s_axis_tdata_i = '0;
  logic         s_axis_tuser_i = 1'b0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [23:0]  m_axis_tdata_o;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [1:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  vector_target_region_classifier dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Items waiting to be offered, and the verdicts predicted for accepted items.
  vector_item_t  pending_q[$];
  verdict_t      verdict_q[$];

  // The predictor's view of the block, updated as items are accepted.
  region_entry_t region_shadow[TableDepth];
  logic [4:0]    active_regions = '0;

  // The stimulus generator's own view of the table, updated as items are queued.
  region_entry_t region_plan[TableDepth];

  int unsigned queued_total = 0;
  int unsigned items_in = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned in_idle_pct = 26;
  int unsigned out_idle_pct = 26;
  int unsigned holds_asked = 0;
  int unsigned holds_granted = 0;
  int unsigned hold_left = 0;
  logic        in_taken = 1'b0;
  vector_item_t next_item;
  verdict_t     got_verdict;
  verdict_t     want_verdict;

  // Works out the verdict for one item and applies the table write of a load.
  function automatic verdict_t classify_item(vector_item_t it);
    verdict_t    v;
    int unsigned live;
    v = '0;
    if (it.mode == MODE_LOAD) begin
      // A four-bit slot index always falls inside the sixteen-entry table.
      region_shadow[it.f.slot].lo         = it.f.lo;
      region_shadow[it.f.slot].hi         = it.f.hi;
      region_shadow[it.f.slot].attr.exec  = it.f.exec;
      region_shadow[it.f.slot].attr.patch = it.f.patch;
      region_shadow[it.f.slot].attr.owner = it.f.owner;
      return v;
    end
    // A hit in the expected range ends the analysis without a table search.
    if (it.f.exp_lo <= it.f.exp_hi && it.f.target >= it.f.exp_lo &&
        it.f.target <= it.f.exp_hi) begin
      v.in_expected = 1'b1;
      v.finding     = FIND_EXPECTED;
      v.finding_cnt = 2'd1;
      return v;
    end
    live = (active_regions > TableDepth) ? TableDepth : active_regions;
    for (int i = 0; i < live && !v.in_known; i++) begin
      if (region_shadow[i].lo <= region_shadow[i].hi &&
          it.f.target >= region_shadow[i].lo && it.f.target <= region_shadow[i].hi) begin
        v.in_known   = 1'b1;
        v.executable = region_shadow[i].attr.exec;
        v.patchable  = region_shadow[i].attr.patch;
        v.owner      = region_shadow[i].attr.owner;
        v.region_idx = 4'(i);
      end
    end
    v.score = SCORE_BASE;
    if (!v.in_known) begin
      v.finding = FIND_UNKNOWN;
      v.score   = v.score + WEIGHT_UNKNOWN;
    end else if (v.patchable) begin
      v.finding = FIND_ALLOWED_PATCH;
      v.score   = v.score - WEIGHT_PATCH;
    end else if (!v.executable) begin
      v.finding = FIND_NONEXEC;
      v.score   = v.score + WEIGHT_NONEXEC;
    end else if (v.owner == OWNER_ROM) begin
      v.finding = FIND_ROM;
    end else if (v.owner == OWNER_LIBRARY || v.owner == OWNER_DEVICE ||
                 v.owner == OWNER_RESIDENT) begin
      v.finding = FIND_KNOWN_MODULE;
      v.score   = v.score + WEIGHT_MODULE;
    end else begin
      v.finding = FIND_EXEC_RAM;
      v.score   = v.score + WEIGHT_RAM;
    end
    v.finding_cnt = 2'd2;
    return v;
  endfunction

  function automatic region_entry_t region(logic [31:0] lo, logic [31:0] hi, logic exec,
                                           logic patch, logic [2:0] owner);
    region_entry_t e;
    e.lo         = lo;
    e.hi         = hi;
    e.attr.exec  = exec;
    e.attr.patch = patch;
    e.attr.owner = owner;
    return e;
  endfunction

  // Load items carry random bits in the analyse fields, which the block must ignore.
  function automatic void queue_load(logic [3:0] slot, region_entry_t e);
    vector_item_t it;
    it.mode     = MODE_LOAD;
    it.f.spare  = '0;
    it.f.slot   = slot;
    it.f.lo     = e.lo;
    it.f.hi     = e.hi;
    it.f.exec   = e.attr.exec;
    it.f.patch  = e.attr.patch;
    it.f.owner  = e.attr.owner;
    it.f.target = $urandom;
    it.f.exp_lo = $urandom;
    it.f.exp_hi = $urandom;
    region_plan[slot] = e;
    pending_q.push_back(it);
    queued_total++;
  endfunction

  // Analyse items likewise carry random bits in the load fields.
  function automatic void queue_probe(logic [31:0] target, logic [31:0] exp_lo,
                                      logic [31:0] exp_hi);
    vector_item_t it;
    it.mode     = MODE_ANALYZE;
    it.f.spare  = '0;
    it.f.slot   = 4'($urandom);
    it.f.lo     = $urandom;
    it.f.hi     = $urandom;
    it.f.exec   = 1'($urandom);
    it.f.patch  = 1'($urandom);
    it.f.owner  = 3'($urandom);
    it.f.target = target;
    it.f.exp_lo = exp_lo;
    it.f.exp_hi = exp_hi;
    pending_q.push_back(it);
    queued_total++;
  endfunction

  // Uniform address within [lo, hi]; any address when the region is inverted.
  function automatic logic [31:0] pick_in(logic [31:0] lo, logic [31:0] hi);
    longint span;
    if (lo > hi) return $urandom;
    span = longint'(hi) - longint'(lo) + 1;
    return lo + 32'(longint'($urandom) % span);
  endfunction

  // Mostly small regions, so that targets land in a chosen one, with the odd
  // full-range, inverted, single-address or edge-of-space region.
  function automatic region_entry_t make_region();
    region_entry_t e;
    logic [31:0]   a;
    logic [31:0]   b;
    a = $urandom;
    b = $urandom;
    e.attr.exec  = 1'($urandom_range(1, 0));
    e.attr.patch = 1'($urandom_range(1, 0));
    e.attr.owner = 3'($urandom_range(7, 0));
    case ($urandom_range(19, 0))
      0: begin
        e.lo = '0;
        e.hi = '1;
      end
      1: begin
        e.lo = (a > b) ? a : b;
        e.hi = (a > b) ? b : a;
      end
      2: begin
        e.lo = a;
        e.hi = a;
      end
      3: begin
        e.lo = 32'hFFFF_FFFF - $urandom_range(65535, 0);
        e.hi = '1;
      end
      4: begin
        e.lo = '0;
        e.hi = $urandom_range(65535, 0);
      end
      5: begin
        e.lo = a | 32'd1;
        e.hi = e.lo - 32'd1;
      end
      default: begin
        e.lo = a;
        e.hi = (a > 32'hFFFF_F000) ? '1 : a + $urandom_range(4095, 0);
      end
    endcase
    return e;
  endfunction

  // Aims most targets at an active region, the rest at its edges or anywhere.
  function automatic void queue_random_probe();
    int unsigned   live;
    int unsigned   r;
    region_entry_t e;
    logic [31:0]   t;
    logic [31:0]   a;
    logic [31:0]   b;
    logic [31:0]   lo;
    logic [31:0]   hi;
    live = (active_regions > TableDepth) ? TableDepth : active_regions;
    e = region_plan[(live == 0) ? $urandom_range(TableDepth - 1, 0) : $urandom_range(live - 1, 0)];
    case ($urandom_range(9, 0))
      0, 1, 2, 3, 4, 5: t = pick_in(e.lo, e.hi);
      6:                t = $urandom_range(1, 0) ? e.lo - 32'd1 : e.hi + 32'd1;
      7:                t = $urandom_range(1, 0) ? e.lo : e.hi;
      8:                t = $urandom;
      default:          t = $urandom_range(1, 0) ? '0 : '1;
    endcase
    a = $urandom;
    b = $urandom;
    case ($urandom_range(9, 0))
      0, 1, 2: begin
        r  = $urandom_range(255, 0);
        lo = (t < r) ? '0 : t - r;
        hi = (t > 32'hFFFF_FFFF - r) ? '1 : t + r;
      end
      3: begin
        lo = t;
        hi = t;
      end
      4: begin
        lo = a;
        hi = b;
      end
      5: begin
        // Inverted expected range, which cannot hold the target unless both random ends are equal.
        lo = (a > b) ? a : b;
        hi = (a > b) ? b : a;
      end
      default: begin
        lo = a;
        hi = (a > 32'hFFFF_0000) ? '1 : a + $urandom_range(65535, 0);
      end
    endcase
    queue_probe(t, lo, hi);
  endfunction

  task automatic write_register(input logic [1:0] addr, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == LiveSlotsAddr) active_regions = value[4:0];
  endtask

  // Returns once every queued item has been accepted and every verdict checked.
  task automatic wait_idle();
    while (items_in != queued_total || verdict_q.size() != 0) @(negedge clk_i);
  endtask

  // Sender: holds an offered item until it is taken, then idles or offers the next.
  always @(negedge clk_i) begin
    if (!s_axis_tvalid_i || in_taken) begin
      if (rst_ni && pending_q.size() != 0 && $urandom_range(99, 0) >= in_idle_pct) begin
        next_item = pending_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= next_item.f;
        s_axis_tuser_i  <= next_item.mode;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold whenever one is asked for.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left       <= hold_left - 1;
    end else if (holds_granted != holds_asked) begin
      m_axis_tready_i <= 1'b0;
      hold_left       <= LongHold;
      holds_granted   <= holds_granted + 1;
    end else begin
      m_axis_tready_i <= ($urandom_range(99, 0) >= out_idle_pct);
    end
  end

  // Monitor: predicts each accepted item and checks each accepted verdict in order.
  always @(posedge clk_i) begin
    in_taken <= s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      verdict_q.push_back(classify_item(vector_item_t'({s_axis_tuser_i, s_axis_tdata_i})));
      items_in++;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_verdict = verdict_t'(m_axis_tdata_o);
      if (verdict_q.size() == 0) begin
        fail_count++;
        if (fail_count <= ReportMax)
          $display("%0t: verdict %h arrived with nothing expected", $realtime, m_axis_tdata_o);
      end else begin
        want_verdict = verdict_q.pop_front();
        if (got_verdict.in_expected != want_verdict.in_expected ||
            got_verdict.in_known    != want_verdict.in_known ||
            got_verdict.executable  != want_verdict.executable ||
            got_verdict.patchable   != want_verdict.patchable ||
            got_verdict.owner       != want_verdict.owner ||
            got_verdict.region_idx  != want_verdict.region_idx ||
            got_verdict.finding     != want_verdict.finding ||
            got_verdict.finding_cnt != want_verdict.finding_cnt ||
            got_verdict.score       != want_verdict.score ||
            got_verdict.spare       != want_verdict.spare) begin
          fail_count++;
          if (fail_count <= ReportMax) begin
            $display("%0t: verdict mismatch (exp known exe pat own idx find cnt score spare)",
                     $realtime);
            $display("  expected %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                     want_verdict.in_expected, want_verdict.in_known,
                     want_verdict.executable, want_verdict.patchable, want_verdict.owner,
                     want_verdict.region_idx, want_verdict.finding,
                     want_verdict.finding_cnt, want_verdict.score, want_verdict.spare);
            $display("  actual   %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                     got_verdict.in_expected, got_verdict.in_known,
                     got_verdict.executable, got_verdict.patchable, got_verdict.owner,
                     got_verdict.region_idx, got_verdict.finding,
                     got_verdict.finding_cnt, got_verdict.score, got_verdict.spare);
          end
        end
      end
    end
  end

  // Watchdog: a long run of cycles with no item moving on either side is a hang.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [4:0] phase_limits[NumPhases];
    phase_limits = '{5'd16, 5'd5, 5'd0, 5'd31, 5'd1, 5'd17, 5'd10, 5'd16};
    phase_limits[6] = 5'($urandom_range(15, 2));

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // With no active regions every miss of the expected range is unknown.
    queue_probe(32'h0000_1800, 32'h0000_0000, 32'h0000_0000);

    // Fill the whole table: one region per owner kind and flag combination, an
    // inverted region, an overlap that loses on priority, and both address extremes.
    queue_load(4'd0,  region(32'h0000_1000, 32'h0000_1FFF, 1'b1, 1'b0, OWNER_ROM));
    queue_load(4'd1,  region(32'h0000_2000, 32'h0000_2FFF, 1'b1, 1'b0, OWNER_LIBRARY));
    queue_load(4'd2,  region(32'h0000_3000, 32'h0000_3FFF, 1'b1, 1'b0, OWNER_DEVICE));
    queue_load(4'd3,  region(32'h0000_4000, 32'h0000_4FFF, 1'b1, 1'b0, OWNER_RESIDENT));
    queue_load(4'd4,  region(32'h0000_5000, 32'h0000_5FFF, 1'b1, 1'b0, OWNER_UNKNOWN));
    queue_load(4'd5,  region(32'h0000_6000, 32'h0000_6FFF, 1'b1, 1'b0, OwnerOtherHi));
    queue_load(4'd6,  region(32'h0000_7000, 32'h0000_7FFF, 1'b0, 1'b0, OwnerOtherLo));
    queue_load(4'd7,  region(32'h0000_8000, 32'h0000_8FFF, 1'b1, 1'b1, OWNER_ROM));
    queue_load(4'd8,  region(32'h0000_9FFF, 32'h0000_9000, 1'b1, 1'b0, OWNER_ROM));
    queue_load(4'd9,  region(32'h0000_9000, 32'h0000_9FFF, 1'b1, 1'b1, OWNER_ROM));
    queue_load(4'd10, region(32'h0000_1000, 32'h0000_1000, 1'b0, 1'b1, OWNER_DEVICE));
    queue_load(4'd11, region(32'hFFFF_F000, 32'hFFFF_FFFF, 1'b0, 1'b1, OWNER_DEVICE));
    queue_load(4'd12, region(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, OWNER_RESIDENT));
    queue_load(4'd13, region(32'h0000_A000, 32'h0000_AFFF, 1'b0, 1'b1, OWNER_LIBRARY));
    queue_load(4'd14, region(32'h0000_B000, 32'h0000_B000, 1'b1, 1'b0, OwnerOtherLo));
    queue_load(4'd15, region(32'h8000_0000, 32'hBFFF_FFFF, 1'b1, 1'b0, OWNER_ROM));
    wait_idle();
    write_register(LiveSlotsAddr, 32'd16);

    queue_probe(32'h0000_1000, 32'h0000_0000, 32'h0000_0FFF);  // slot 0 beats slot 10
    queue_probe(32'h0000_2000, 32'h0001_0000, 32'h0001_00FF);  // library
    queue_probe(32'h0000_3FFF, 32'h0001_0000, 32'h0001_00FF);  // device
    queue_probe(32'h0000_4800, 32'h0001_0000, 32'h0001_00FF);  // resident
    queue_probe(32'h0000_5000, 32'h0000_6000, 32'h0000_4000);  // inverted expected range
    queue_probe(32'h0000_6FFF, 32'h0001_0000, 32'h0001_00FF);  // executable RAM
    queue_probe(32'h0000_7000, 32'h0001_0000, 32'h0001_00FF);  // not executable
    queue_probe(32'h0000_9000, 32'h0001_0000, 32'h0001_00FF);  // inverted region skipped
    queue_probe(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFE);  // top of the address space
    queue_probe(32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF);  // bottom of the address space
    queue_probe(32'hC000_0000, 32'h0001_0000, 32'h0001_00FF);  // outside every region
    queue_probe(32'h0000_8000, 32'h0000_0000, 32'hFFFF_FFFF);  // expected hit
    wait_idle();

    // Random phases, each under its own region count, from none active to an
    // out-of-range count that the block clamps to the table size.
    for (int p = 0; p < NumPhases; p++) begin
      write_register(LiveSlotsAddr, 32'(phase_limits[p]));
      in_idle_pct  = (p == 3) ? 0 : 26;
      out_idle_pct = (p == 3) ? 0 : 26;
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(3, 0) == 0)
          queue_load(4'($urandom_range(TableDepth - 1, 0)), make_region());
        else
          queue_random_probe();
      end
      // A long receiver hold while the sender keeps offering fills the pipeline.
      if (p == 1 || p == 4) holds_asked++;
      wait_idle();
    end

    repeat (DrainWait) @(posedge clk_i);
    if (fail_count == 0 && verdict_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/vtrc_pkg.sv
rtl/core/vtrc_region_match.sv
rtl/core/vector_target_region_classifier.sv
tb/sv/tb_top.sv
